// File: rtl/core/nlv_pkg.sv
// Shared types and constants for the numeric literal validator.
package nlv_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned STAGE_W = 4;

    // Character codes that the recognizer distinguishes.
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_EXP_L = 8'h65;
    localparam logic [CH_W-1:0] CH_EXP_U = 8'h45;

    // Recognizer states; the code is reported on the result stream.
    typedef enum logic [STAGE_W-1:0] {
        ST_INVALID    = 4'd0,
        ST_START      = 4'd1,
        ST_SIGN       = 4'd2,
        ST_INT        = 4'd3,
        ST_POINT      = 4'd4,
        ST_FRAC       = 4'd5,
        ST_EXP        = 4'd6,
        ST_EXP_SIGN   = 4'd7,
        ST_EXP_DIGIT  = 4'd8,
        ST_LEAD_POINT = 4'd9
    } t_state;

    // Character classes.
    typedef enum logic [2:0] {
        CL_POINT,
        CL_SIGN,
        CL_EXP,
        CL_DIGIT,
        CL_OTHER
    } t_class;

    // Outcome of one recognizer step.
    typedef struct packed {
        logic   accepted;
        t_state stage;
    } t_step_res;

endpackage

// File: rtl/core/nlv_step.sv
// Character classifier and next-state logic of the recognizer.
module nlv_step (
    input  nlv_pkg::t_state           i_state,
    input  logic [nlv_pkg::CH_W-1:0]  i_ch,
    input  logic                      i_filter,
    output nlv_pkg::t_step_res        o_res
);
    import nlv_pkg::*;

    t_class w_cls;
    t_state w_next;
    t_state w_stage;

    always_comb begin
        priority if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            w_cls = CL_DIGIT;
        end else if (i_ch == CH_POINT) begin
            w_cls = CL_POINT;
        end else if (i_ch == CH_PLUS || i_ch == CH_MINUS) begin
            w_cls = CL_SIGN;
        end else if (i_ch == CH_EXP_L || i_ch == CH_EXP_U) begin
            w_cls = CL_EXP;
        end else begin
            w_cls = CL_OTHER;
        end
    end

    always_comb begin
        w_next = ST_INVALID;
        unique case (i_state)
            ST_START, ST_SIGN: begin
                if (w_cls == CL_POINT) w_next = ST_LEAD_POINT;
                else if (w_cls == CL_DIGIT) w_next = ST_INT;
                else if (w_cls == CL_SIGN && i_state == ST_START) w_next = ST_SIGN;
            end
            ST_INT: begin
                if (w_cls == CL_POINT) w_next = ST_POINT;
                else if (w_cls == CL_EXP) w_next = ST_EXP;
                else if (w_cls == CL_DIGIT) w_next = ST_INT;
            end
            ST_POINT, ST_FRAC: begin
                if (w_cls == CL_EXP) w_next = ST_EXP;
                else if (w_cls == CL_DIGIT) w_next = ST_FRAC;
            end
            ST_EXP: begin
                if (w_cls == CL_SIGN) w_next = ST_EXP_SIGN;
                else if (w_cls == CL_DIGIT) w_next = ST_EXP_DIGIT;
            end
            ST_EXP_SIGN, ST_EXP_DIGIT: begin
                if (w_cls == CL_DIGIT) w_next = ST_EXP_DIGIT;
            end
            ST_LEAD_POINT: begin
                if (w_cls == CL_DIGIT) w_next = ST_FRAC;
            end
            default: begin
                w_next = ST_INVALID;
            end
        endcase
    end

    // In filter mode an unrecognized character leaves the state alone.
    assign w_stage = (i_filter && w_cls == CL_OTHER) ? i_state : w_next;

    assign o_res.stage    = w_stage;
    assign o_res.accepted = (w_stage == ST_INT) || (w_stage == ST_POINT) ||
                            (w_stage == ST_FRAC) || (w_stage == ST_EXP_DIGIT);

endmodule

// File: rtl/core/numeric_literal_validator.sv
// Top level of the streaming decimal number literal validator.
//
//  Channel   Direction  Payload (low bit first)              Transfer when
//  s_axis    in         tdata: ch[7:0]; tlast: last          tvalid & tready
//  m_axis    out        tdata: parse_stage[3:0], zero pad;   tvalid & tready
//                       tuser: accepted; tlast: end_of_string
//  cfg       in         i_cfg_data: filter_mode              i_cfg_valid & o_cfg_ready
//
// Each character is held first in the input register and then in the
// result register, from which its result is offered on m_axis. One
// character is taken every cycle while m_axis does not stall. The rate is
// set by the single recognizer step between the two registers, which also
// updates the state. Reset (synchronous, active low) empties both
// registers, puts the recognizer in its start state and clears filter
// mode. A stall on m_axis holds the result register. Once the input
// register also holds a character, s_axis tready is low for as long as
// m_axis tready stays low.
module numeric_literal_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input characters.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,
    // Results.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] parse_stage, [7:4] zero
    output logic [0:0] m_axis_tuser,   // [0] accepted
    output logic       m_axis_tlast,
    // Configuration.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_data      // [0] filter_mode
);
    import nlv_pkg::*;

    // Input register stage.
    logic             r_in_vld;
    logic [CH_W-1:0]  r_in_ch;
    logic             r_in_last;

    // Result register stage.
    logic             r_out_vld;
    t_step_res        r_out_res;
    logic             r_out_last;

    // Recognizer state and configuration.
    t_state           r_state;
    t_state           n_state;
    logic             r_filter;

    t_step_res        w_res;
    logic             w_out_free;
    logic             w_move;
    logic             w_in_take;

    nlv_step u_step (
        .i_state  (r_state),
        .i_ch     (r_in_ch),
        .i_filter (r_filter),
        .o_res    (w_res)
    );

    // The result register can take a new value when it is empty or being
    // drained in this cycle; the input register follows the same rule one
    // stage earlier, which gives a full-rate two-stage pipeline.
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_move        = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // After the last character of a string the recognizer starts over.
    assign n_state = w_move ? (r_in_last ? ST_START : w_res.stage) : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_res  <= w_res;
            r_out_last <= r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration is to be written only while the stream is idle; the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_filter <= i_cfg_data[0];
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = {{(8 - STAGE_W){1'b0}}, r_out_res.stage};
    assign m_axis_tuser[0] = r_out_res.accepted;
    assign m_axis_tlast    = r_out_last;

    // A reported stage is always one of the ten recognizer codes.
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9 && m_axis_tdata[7:4] == 4'd0))
        else $error("result stage out of range");

    // The verdict agrees with the reported stage.
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] ==
            (r_out_res.stage == ST_INT || r_out_res.stage == ST_POINT ||
             r_out_res.stage == ST_FRAC || r_out_res.stage == ST_EXP_DIGIT)))
        else $error("verdict does not match stage");

    // The end of a string puts the recognizer back in its start state.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in_last) |=> (r_state == ST_START))
        else $error("recognizer did not restart after end of string");

    // A stalled result keeps the recognizer state from running ahead by more
    // than the one character held in the input register.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready && r_in_vld) |=> $stable(r_state))
        else $error("recognizer state changed during a full stall");

endmodule
